// ----- design/pngu_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter.
// Used by every module of the block; depends on nothing.
`default_nettype none
package pngu_pkg;

	localparam int MAX_ROW_PIXELS  = 16384;
	localparam int MAX_PIXEL_BYTES = 4;
	localparam int STORE_DEPTH     = MAX_ROW_PIXELS * MAX_PIXEL_BYTES;
	localparam int POS_W           = $clog2(STORE_DEPTH);
	localparam int LEN_W           = POS_W + 1;
	localparam int SEL_W           = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
	localparam int BPP_W           = 3;
	localparam int ROW_W           = 15;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 15;
	localparam int Q_DEPTH         = 4;
	localparam int Q_AW            = $clog2(Q_DEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_BPP       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filter_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       end_of_row;
		logic       status;
	} out_item_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic             is_err;
		logic [7:0]       data;
		filter_t          filter;
		logic [POS_W-1:0] pos;
		logic [SEL_W-1:0] sel;
		logic             a_ok;
		logic             c_ok;
		logic             first_row;
		logic             last;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t work;
	} push_t;

	typedef struct packed {
		logic  valid;
		work_t work;
	} head_t;

endpackage
`default_nettype wire

// ----- design/pngu_front.sv -----
// Front end: config registers, item acceptance, row/position tracking.
// Classifies each byte and pushes pixel and error work to the queue. Uses pngu_pkg.
`default_nettype none
module pngu_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	output logic                             item_ready,
	input  pngu_pkg::in_item_t               item,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [pngu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [pngu_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                              q_full,
	output pngu_pkg::push_t                  push
);
	import pngu_pkg::*;

	logic [BPP_W-1:0] bpp_q;
	logic [ROW_W-1:0] width_q;
	logic [POS_W-1:0] pos_q;
	filter_t          filter_q;
	logic             expect_q;
	logic             first_q;
	logic             err_q;

	logic [BPP_W-1:0] bpp_sat;
	logic [ROW_W-1:0] w_sat;
	logic [LEN_W-1:0] row_len;
	logic [LEN_W-1:0] pos_inc;
	logic             last;
	logic             take;
	logic             expect_e, first_e, err_e;

	assign cfg_ready  = 1'b1;
	assign item_ready = !q_full;
	assign take       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q   <= BPP_W'(1);
			width_q <= ROW_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BPP:       bpp_q   <= cfg_data[BPP_W-1:0];
				REG_ROW_WIDTH: width_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bpp_q == '0)
			bpp_sat = BPP_W'(1);
		else if (bpp_q > BPP_W'(MAX_PIXEL_BYTES))
			bpp_sat = BPP_W'(MAX_PIXEL_BYTES);
		else
			bpp_sat = bpp_q;
		if (width_q == '0)
			w_sat = ROW_W'(1);
		else if (width_q > ROW_W'(MAX_ROW_PIXELS))
			w_sat = ROW_W'(MAX_ROW_PIXELS);
		else
			w_sat = width_q;
		row_len  = LEN_W'(w_sat) * LEN_W'(bpp_sat);
		pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
		last     = pos_inc >= row_len;
		expect_e = item.image_start ? 1'b1 : expect_q;
		first_e  = item.image_start ? 1'b1 : first_q;
		err_e    = item.image_start ? 1'b0 : err_q;
	end

	always_comb begin
		push.valid          = 1'b0;
		push.work.is_err    = 1'b0;
		push.work.data      = item.data_byte;
		push.work.filter    = filter_q;
		push.work.pos       = pos_q;
		push.work.sel       = SEL_W'(bpp_sat - BPP_W'(1));
		push.work.a_ok      = pos_q >= POS_W'(bpp_sat);
		push.work.c_ok      = !first_e && (pos_q >= POS_W'(bpp_sat));
		push.work.first_row = first_e;
		push.work.last      = last;
		if (take && !err_e) begin
			if (expect_e) begin
				push.valid       = item.data_byte > 8'(FILT_PAETH);
				push.work.is_err = 1'b1;
			end else begin
				push.valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filter_q <= FILT_NONE;
			expect_q <= 1'b1;
			first_q  <= 1'b1;
			err_q    <= 1'b0;
		end else if (take) begin
			expect_q <= expect_e;
			first_q  <= first_e;
			err_q    <= err_e;
			if (!err_e) begin
				if (expect_e) begin
					pos_q <= '0;
					if (item.data_byte > 8'(FILT_PAETH)) begin
						err_q <= 1'b1;
					end else begin
						filter_q <= filter_t'(item.data_byte[2:0]);
						expect_q <= 1'b0;
					end
				end else if (last) begin
					pos_q    <= '0;
					expect_q <= 1'b1;
					first_q  <= 1'b0;
				end else begin
					pos_q <= pos_inc[POS_W-1:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/pngu_queue.sv -----
// Short work queue between front and back of the unfilter.
// Register-based ring buffer; uses pngu_pkg.
`default_nettype none
module pngu_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  pngu_pkg::push_t push,
	output logic            full,
	output pngu_pkg::head_t head,
	input  wire             pop
);
	import pngu_pkg::*;

	work_t          buf_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push, do_pop;

	assign full       = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.work  = buf_q[rd_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push)
			buf_q[wr_q] <= push.work;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == Q_AW'(Q_DEPTH-1)) ? '0 : wr_q + Q_AW'(1);
			if (do_pop)
				rd_q <= (rd_q == Q_AW'(Q_DEPTH-1)) ? '0 : rd_q + Q_AW'(1);
			cnt_q <= cnt_q + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ----- design/pngu_back.sv -----
// Back end: line store, neighbor registers, filter reconstruction, result register.
// Pops work from pngu_queue; uses pngu_pkg.
`default_nettype none
module pngu_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pngu_pkg::head_t     head,
	output logic                pop,
	output logic                res_valid,
	input  wire                 res_ready,
	output pngu_pkg::out_item_t res
);
	import pngu_pkg::*;

	logic [7:0]       mem_q [STORE_DEPTH];
	logic [7:0]       left_q [MAX_PIXEL_BYTES];
	logic [7:0]       ul_q [MAX_PIXEL_BYTES];
	logic             s1_valid_q;
	work_t            s1_q;
	logic [7:0]       rd_q;
	logic             byp_q;
	logic [7:0]       bypv_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             advance, wr_en;
	logic [7:0]       a, b, c, pred, v;
	logic signed [9:0] pa, pb, pc;
	logic [8:0]       avg;

	assign advance   = s1_valid_q && (!out_valid_q || res_ready);
	assign pop       = head.valid && (!s1_valid_q || advance);
	assign wr_en     = advance && !s1_q.is_err;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		a   = s1_q.a_ok ? left_q[s1_q.sel] : 8'd0;
		b   = s1_q.first_row ? 8'd0 : (byp_q ? bypv_q : rd_q);
		c   = s1_q.c_ok ? ul_q[s1_q.sel] : 8'd0;
		pa  = 10'(signed'({2'b00, b})) - 10'(signed'({2'b00, c}));
		pb  = 10'(signed'({2'b00, a})) - 10'(signed'({2'b00, c}));
		pc  = pa + pb;
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		avg = 9'(a) + 9'(b);
		unique case (s1_q.filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg[8:1];
			FILT_PAETH: begin
				if (pa <= pb && pa <= pc)
					pred = a;
				else if (pb <= pc)
					pred = b;
				else
					pred = c;
			end
			default:    pred = 8'd0;
		endcase
		v = s1_q.data + pred;
	end

	// line store: read on pop, write as the pixel leaves s1
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q   <= mem_q[head.work.pos];
			byp_q  <= wr_en && (s1_q.pos == head.work.pos);
			bypv_q <= v;
		end
		if (wr_en)
			mem_q[s1_q.pos] <= v;
	end

	always_ff @(posedge clk) begin
		if (pop)
			s1_q <= head.work;
		if (advance) begin
			out_q.pixel_byte <= s1_q.is_err ? 8'd0 : v;
			out_q.end_of_row <= s1_q.is_err ? 1'b0 : s1_q.last;
			out_q.status     <= s1_q.is_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= '0;
				ul_q[i]   <= '0;
			end
		end else begin
			if (pop)
				s1_valid_q <= 1'b1;
			else if (advance)
				s1_valid_q <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
			if (wr_en) begin
				left_q[0] <= v;
				ul_q[0]   <= b;
				for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i] <= left_q[i-1];
					ul_q[i]   <= ul_q[i-1];
				end
			end
		end
	end

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status |-> res.pixel_byte == 8'd0 && !res.end_of_row)
		else $error("error item carries pixel data");

	a_byp_src: assert property (@(posedge clk) disable iff (!arst_n)
		pop && wr_en && (s1_q.pos == head.work.pos) |=> byp_q)
		else $error("line store bypass missed");

	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid && (!s1_valid_q || advance))
		else $error("pop without room in s1");

	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid)
		else $error("result lost leaving s1");

endmodule
`default_nettype wire

// ----- design/png_scanline_unfilter_top.sv -----
// Top level of the PNG scanline unfilter: front end, work queue and back end.
// Depends on pngu_pkg, pngu_front, pngu_queue and pngu_back.
//
// Takes one stream byte per clock while the work queue is not full and gives at
// most one result item per byte: none for a valid filter byte, an error item for
// a bad one. A pixel byte passes the queue, s1 and result registers to res, at a
// sustained rate of one per cycle while res_ready is high, set by the single read
// and single write port of the 64 KiB line store, whose read-after-write case is
// covered by a bypass register. The line store has no reset and no clearing pass:
// a row longer than any earlier row since reset reads unwritten entries. Configure
// bytes_per_pixel and row_width only while no item is in flight.
`default_nettype none
module png_scanline_unfilter_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	output logic                             item_ready,
	input  pngu_pkg::in_item_t               item,
	output logic                             res_valid,
	input  wire                              res_ready,
	output pngu_pkg::out_item_t              res,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [pngu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [pngu_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pngu_pkg::*;

	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;

	pngu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.push       (push)
	);

	pngu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	pngu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
`default_nettype wire

// ----- tb/sv/tb_png_scanline_unfilter_top.sv -----
// Testbench for png_scanline_unfilter_top: a directed table, then random phases of
// filtered rows checked against an in-bench model of PNG row reconstruction.
// Depends on pngu_pkg and the RTL of png_scanline_unfilter_top.
`timescale 1ns / 100ps
module tb_png_scanline_unfilter_top;
	import pngu_pkg::*;

	localparam int N_PHASES    = 24;
	localparam int PHASE_ITEMS = 70;
	localparam int HOLD_PHASE  = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 8;
	localparam int END_WAIT    = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_DIR       = 21;
	localparam int WIDE_ROW    = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
	localparam logic [7:0]           BAD_FILTER  = 8'd5;

	typedef enum logic [1:0] {
		CHK_NONE,
		CHK_FIXED,
		CHK_MODEL
	} chk_t;

	typedef struct packed {
		in_item_t  item;
		chk_t      chk;
		out_item_t res;
	} dir_row_t;

	localparam out_item_t NO_RES  = '0;
	localparam out_item_t ERR_RES = {8'h00, 1'b0, 1'b1};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	in_item_t              item;
	logic                  res_valid;
	logic                  res_ready;
	out_item_t             res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// model state
	logic [2:0]            cfg_bpp;
	logic [14:0]           cfg_width;
	logic [7:0]            row_mem [STORE_DEPTH];
	logic [7:0]            left_q [MAX_PIXEL_BYTES];
	logic [7:0]            upleft_q [MAX_PIXEL_BYTES];
	int unsigned           rd_pos;
	int unsigned           store_fill;
	filter_t               cur_filter;
	bit                    want_filter;
	bit                    first_row;
	bit                    err_hold;

	out_item_t             pending_pixels [$];
	out_item_t             want;
	dir_row_t              dir_rows [N_DIR];
	int                    fix_bpp [8] = '{0, 7, 4, 1, 4, 5, 2, 3};
	int                    fix_width [8] = '{0, 32767, 16384, 16384, 1, 16385, 3, 12};
	int unsigned           cut_at = 16;
	int                    phase_no = -1;
	bit                    quiet = 1'b0;
	bit                    hold_done = 1'b0;
	int                    mismatches = 0;
	int                    results_seen = 0;
	int                    cycle_count = 0;

	png_scanline_unfilter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL png_scanline_unfilter_top");
			$finish;
		end
	end

	function automatic int unsigned stream_row_len();
		int unsigned bpp;
		int unsigned w;
		bpp = cfg_bpp;
		w = cfg_width;
		if (bpp < 1) bpp = 1;
		if (bpp > MAX_PIXEL_BYTES) bpp = MAX_PIXEL_BYTES;
		if (w < 1) w = 1;
		if (w > MAX_ROW_PIXELS) w = MAX_ROW_PIXELS;
		return w * bpp;
	endfunction

	function automatic int unsigned paeth_select(input int unsigned a, b, c);
		int p;
		int pa;
		int pb;
		int pc;
		p = int'(a) + int'(b) - int'(c);
		pa = p - int'(a);
		pb = p - int'(b);
		pc = p - int'(c);
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

	task automatic unfilter_byte(input in_item_t it, output bit has_res, output out_item_t r);
		int unsigned bpp;
		int unsigned n;
		int unsigned pos;
		int unsigned a;
		int unsigned b;
		int unsigned c;
		int unsigned pred;
		logic [7:0]  v;
		bit          last;
		bpp = cfg_bpp;
		if (bpp < 1) bpp = 1;
		if (bpp > MAX_PIXEL_BYTES) bpp = MAX_PIXEL_BYTES;
		n = stream_row_len();
		has_res = 1'b0;
		r = NO_RES;
		if (it.image_start) begin
			err_hold = 1'b0;
			first_row = 1'b1;
			want_filter = 1'b1;
		end
		if (err_hold) return;
		if (want_filter) begin
			rd_pos = 0;
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] = 8'h00;
				upleft_q[i] = 8'h00;
			end
			if (it.data_byte > 8'(FILT_PAETH)) begin
				err_hold = 1'b1;
				has_res = 1'b1;
				r = ERR_RES;
				return;
			end
			cur_filter = filter_t'(it.data_byte[2:0]);
			want_filter = 1'b0;
			return;
		end
		pos = rd_pos;
		a = (pos >= bpp) ? left_q[bpp-1] : 0;
		b = first_row ? 0 : row_mem[pos];
		c = (!first_row && pos >= bpp) ? upleft_q[bpp-1] : 0;
		case (cur_filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = (a + b) >> 1;
			FILT_PAETH: pred = paeth_select(a, b, c);
			default:    pred = 0;
		endcase
		v = 8'(it.data_byte + pred);
		row_mem[pos] = v;
		if (pos + 1 > store_fill) store_fill = pos + 1;
		for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
			left_q[i] = left_q[i-1];
			upleft_q[i] = upleft_q[i-1];
		end
		left_q[0] = v;
		upleft_q[0] = 8'(b);
		last = (pos + 1 >= n);
		if (last) begin
			rd_pos = 0;
			want_filter = 1'b1;
			first_row = 1'b0;
		end else begin
			rd_pos = (pos + 1) & 16'hFFFF;
		end
		has_res = 1'b1;
		r = {v, last, 1'b0};
	endtask

	function automatic logic [7:0] pick_filter();
		if ($urandom_range(0, 39) == 0) return 8'($urandom_range(5, 255));
		return 8'($urandom_range(0, 4));
	endfunction

	// next stream byte; never lets a later row read past what earlier rows wrote
	function automatic in_item_t pick_byte();
		in_item_t    it;
		int unsigned n;
		n = stream_row_len();
		it.image_start = 1'b0;
		it.data_byte = 8'($urandom_range(0, 255));
		if (err_hold) begin
			if ($urandom_range(0, 3) != 0) begin
				it.image_start = 1'b1;
				it.data_byte = pick_filter();
				cut_at = $urandom_range(8, 48);
			end
		end else if (want_filter) begin
			it.data_byte = pick_filter();
			it.image_start = ($urandom_range(0, 19) == 0);
			cut_at = $urandom_range(8, 48);
		end else if ((!first_row && rd_pos >= store_fill) ||
		             (n > WIDE_ROW && rd_pos >= cut_at) ||
		             $urandom_range(0, 99) == 0) begin
			it.image_start = 1'b1;
			it.data_byte = pick_filter();
			cut_at = $urandom_range(8, 48);
		end
		return it;
	endfunction

	task automatic offer_byte(input in_item_t it, input chk_t chk, input out_item_t fixed);
		int        gap;
		bit        got;
		out_item_t r;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 16);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		unfilter_byte(it, got, r);
		if (chk == CHK_FIXED) pending_pixels.push_back(fixed);
		else if (chk == CHK_MODEL && got) pending_pixels.push_back(r);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_BPP) cfg_bpp = val[2:0];
		else if (idx == REG_ROW_WIDTH) cfg_width = val;
	endtask

	task automatic drain(input int settle);
		item_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		int       ph;
		int       cnt;
		int       pick;
		in_item_t it;
		bit       noise;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cfg_bpp = 3'd1;
		cfg_width = 15'd1;
		rd_pos = 0;
		store_fill = 0;
		cur_filter = FILT_NONE;
		want_filter = 1'b1;
		first_row = 1'b1;
		err_hold = 1'b0;
		for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
			left_q[i] = 8'h00;
			upleft_q[i] = 8'h00;
		end
		dir_rows = '{
			{8'(FILT_NONE),  1'b0, CHK_NONE,  NO_RES},   // no image start after reset
			{8'hFF,          1'b0, CHK_FIXED, {8'hFF, 1'b1, 1'b0}},
			{8'(FILT_SUB),   1'b0, CHK_NONE,  NO_RES},
			{8'h80,          1'b0, CHK_FIXED, {8'h80, 1'b1, 1'b0}},
			{8'(FILT_UP),    1'b0, CHK_NONE,  NO_RES},
			{8'h01,          1'b0, CHK_MODEL, NO_RES},
			{8'(FILT_AVG),   1'b0, CHK_NONE,  NO_RES},
			{8'h10,          1'b0, CHK_MODEL, NO_RES},
			{8'(FILT_PAETH), 1'b0, CHK_NONE,  NO_RES},
			{8'h00,          1'b0, CHK_MODEL, NO_RES},
			{BAD_FILTER,     1'b0, CHK_FIXED, ERR_RES},
			{8'h33,          1'b0, CHK_NONE,  NO_RES},   // ignored while error held
			{8'(FILT_NONE),  1'b1, CHK_NONE,  NO_RES},
			{8'h07,          1'b0, CHK_FIXED, {8'h07, 1'b1, 1'b0}},
			{8'hFF,          1'b0, CHK_FIXED, ERR_RES},
			{8'hFF,          1'b1, CHK_FIXED, ERR_RES},  // bad filter on image start
			{8'(FILT_PAETH), 1'b1, CHK_NONE,  NO_RES},
			{8'h9C,          1'b0, CHK_MODEL, NO_RES},
			{8'(FILT_UP),    1'b0, CHK_NONE,  NO_RES},
			{8'(FILT_SUB),   1'b1, CHK_NONE,  NO_RES},   // image start mid-row
			{8'h55,          1'b0, CHK_FIXED, {8'h55, 1'b1, 1'b0}}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			offer_byte(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].res);

		for (ph = 0; ph < N_PHASES; ph++) begin
			drain(DRAIN_WAIT);
			quiet = (ph >= N_PHASES - 3);
			if (ph < 8) begin
				write_reg(REG_BPP, CFG_DATA_W'(fix_bpp[ph]));
				write_reg(REG_ROW_WIDTH, CFG_DATA_W'(fix_width[ph]));
			end else begin
				pick = $urandom_range(0, 3);
				if (pick != 1)
					write_reg(REG_BPP, ($urandom_range(0, 5) == 0) ?
					          CFG_DATA_W'($urandom_range(0, 7)) :
					          CFG_DATA_W'($urandom_range(1, 4)));
				if (pick != 0)
					write_reg(REG_ROW_WIDTH, ($urandom_range(0, 9) == 0) ?
					          CFG_DATA_W'($urandom_range(0, 32767)) :
					          CFG_DATA_W'($urandom_range(1, 16)));
			end
			if (ph == 3) begin
				write_reg(REG_SPARE_A, CFG_DATA_W'($urandom_range(0, 32767)));
				write_reg(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 32767)));
			end
			cfg_valid <= 1'b0;
			phase_no = ph;
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				it = pick_byte();
				noise = err_hold && !it.image_start;
				offer_byte(it, CHK_MODEL, NO_RES);
				if (!noise) cnt++;
			end
		end

		drain(END_WAIT);
		if (mismatches == 0)
			$display("PASS png_scanline_unfilter_top");
		else
			$display("FAIL png_scanline_unfilter_top");
		$finish;
	end

	initial begin
		res_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (phase_no == HOLD_PHASE && !hold_done) begin
				// hold the output long enough for the input side to back up
				hold_done = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				res_ready <= 1'b1;
			end else if ($urandom_range(0, 15) == 0) begin
				res_ready <= 1'b1;
				repeat (32) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: result with none expected, got %h", $time, res);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (res.pixel_byte !== want.pixel_byte) begin
					$display("%0t: pixel_byte expected %h got %h", $time,
					         want.pixel_byte, res.pixel_byte);
					mismatches++;
				end
				if (res.end_of_row !== want.end_of_row) begin
					$display("%0t: end_of_row expected %b got %b", $time,
					         want.end_of_row, res.end_of_row);
					mismatches++;
				end
				if (res.status !== want.status) begin
					$display("%0t: status expected %b got %b", $time,
					         want.status, res.status);
					mismatches++;
				end
			end
		end
	end

endmodule

// ----- files.f -----
design/pngu_pkg.sv
design/pngu_front.sv
design/pngu_queue.sv
design/pngu_back.sv
design/png_scanline_unfilter_top.sv
tb/sv/tb_png_scanline_unfilter_top.sv
